// ===== sv/tcss_pkg.sv =====
// ----------------------------------------------------------------------------
// tcss_pkg: shared types and constants of the terminal screen unit
// Byte codes of the control language, function codes, parser and
// sequencer states, and the structs passed between the modules.
// ----------------------------------------------------------------------------
package tcss_pkg;

   // function code carried in tuser of the request channel
   typedef enum logic [1:0] {
      FUNC_FEED = 2'd0,
      FUNC_READ = 2'd1,
      FUNC_NEW  = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   // escape parser phase
   typedef enum logic [1:0] {
      PHASE_NORMAL = 2'd0,
      PHASE_CARET  = 2'd1,
      PHASE_DIGIT  = 2'd2
   } phase_type;

   // top level sequencer
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   localparam logic [7:0] CHAR_CARET   = 8'd94;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_TILDE   = 8'd126;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NINE    = 8'd57;
   localparam logic [7:0] CHAR_LOW_B   = 8'd98;
   localparam logic [7:0] CHAR_LOW_C   = 8'd99;
   localparam logic [7:0] CHAR_LOW_D   = 8'd100;
   localparam logic [7:0] CHAR_LOW_E   = 8'd101;
   localparam logic [7:0] CHAR_LOW_H   = 8'd104;
   localparam logic [7:0] CHAR_LOW_I   = 8'd105;
   localparam logic [7:0] CHAR_LOW_L   = 8'd108;
   localparam logic [7:0] CHAR_LOW_O   = 8'd111;
   localparam logic [7:0] CHAR_LOW_R   = 8'd114;
   localparam logic [7:0] CHAR_LOW_U   = 8'd117;

   // row memory write control
   typedef struct packed {
      logic wr_en;
      logic clear_all;
   } mem_ctl_type;

   // one result transaction
   typedef struct packed {
      logic       insert_on;
      logic [3:0] cursor_col;
      logic [3:0] cursor_row;
      logic [7:0] cell_char;
   } rsp_type;

endpackage

// ===== sv/terminal_control_sequence_screen_unit.sv =====
// ----------------------------------------------------------------------------
// terminal_control_sequence_screen_unit: character-cell terminal screen
// Interprets a byte stream with caret control sequences into a ROWS by
// COLS screen held in a row-wide memory, and answers cell reads.
// ----------------------------------------------------------------------------
// Each request transaction (feed a byte, read a cell, or start a new screen)
// yields exactly one response transaction carrying the cell byte (reads only,
// zero otherwise), the cursor after the request and the insert-mode flag.
// A request is handled in an accepting cycle and an edit cycle: the cycle
// that accepts it also issues the read of one screen row from the row
// memory, and the row is registered at the accepting edge; the edit cycle
// edits that row and writes it back while the response is loaded into the
// output register. The request side is ready again only once the edit
// cycle has ended, so a new request is not taken before the last one is
// committed; a response left waiting in the output register holds the
// edit cycle until it is taken. Clearing the screen (the c code or a new
// screen) runs no clearing pass: a per-row valid bit makes a cleared row
// read as spaces until it is next written, and no clearing pass runs after
// reset.
// ----------------------------------------------------------------------------
module terminal_control_sequence_screen_unit #(
   parameter int ROWS = 10,
   parameter int COLS = 10
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] char_code, [11:8] read_row, [15:12] read_col
   input  logic [1:0]  req_tuser,  // [1:0] func
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // [7:0] cell_char, [11:8] cursor_row,
                                   // [15:12] cursor_col, [16] insert_on, rest zero
);

   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLS);

   tcss_pkg::state_type   state_ff, state_in;
   logic                  accept;
   logic                  commit;

   // latched request
   tcss_pkg::func_type    item_func_ff;
   logic [7:0]            item_char_ff;
   logic [COL_W-1:0]      item_col_ff;
   logic                  item_hit_ff;

   logic [3:0]            req_row, req_col;
   logic                  req_hit;
   tcss_pkg::func_type    req_func;
   logic [ROW_W-1:0]      row_pos;
   logic [ROW_W-1:0]      rd_addr;
   logic [COLS*8-1:0]     row_q;
   logic [COLS*8-1:0]     wr_data;
   tcss_pkg::mem_ctl_type mem_ctl;
   tcss_pkg::rsp_type     result;

   // output register
   logic                  rsp_valid_ff;
   tcss_pkg::rsp_type     rsp_data_ff;

   assign req_func = tcss_pkg::func_type'(req_tuser);
   assign req_row  = req_tdata[11:8];
   assign req_col  = req_tdata[15:12];
   assign req_hit  = (req_row < 4'(ROWS)) && (req_col < 4'(COLS));

   // reads fetch the addressed row (row 0 when off the screen), everything else the cursor row
   assign rd_addr = (req_func == tcss_pkg::FUNC_READ)
                    ? (req_hit ? req_row[ROW_W-1:0] : '0) : row_pos;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcss_pkg::ST_IDLE: if (accept) state_in = tcss_pkg::ST_EXEC;
         tcss_pkg::ST_EXEC: if (commit) state_in = tcss_pkg::ST_IDLE;
         default:           state_in = tcss_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      commit     = 1'b0;
      unique case (state_ff)
         tcss_pkg::ST_IDLE: req_tready = 1'b1;
         tcss_pkg::ST_EXEC: commit = !rsp_valid_ff || rsp_tready;
         default: begin
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the request and the response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_func_ff <= req_func;
         item_char_ff <= req_tdata[7:0];
         item_col_ff  <= req_col[COL_W-1:0];
         item_hit_ff  <= req_hit;
      end
      if (commit) begin
         rsp_data_ff <= result;
      end
   end

   tcss_row_mem #(
      .ROWS  (ROWS),
      .COLS  (COLS),
      .ROW_W (ROW_W)
   ) u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (row_q),
      .ctl     (mem_ctl),
      .wr_addr (row_pos),
      .wr_data (wr_data)
   );

   tcss_engine #(
      .ROWS  (ROWS),
      .COLS  (COLS),
      .ROW_W (ROW_W),
      .COL_W (COL_W)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .commit    (commit),
      .item_func (item_func_ff),
      .item_char (item_char_ff),
      .item_col  (item_col_ff),
      .item_hit  (item_hit_ff),
      .row_q     (row_q),
      .row_pos   (row_pos),
      .mem_ctl   (mem_ctl),
      .wr_data   (wr_data),
      .result    (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

   // an accepted transaction always moves into the edit cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == tcss_pkg::ST_EXEC))
      else $error("accepted transaction did not enter edit cycle");

   // memory writes and clears only happen in the edit cycle
   a_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      (mem_ctl.wr_en || mem_ctl.clear_all) |-> (state_ff == tcss_pkg::ST_EXEC))
      else $error("row memory written outside edit cycle");

   // a committed transaction is presented on the next cycle
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_tvalid)
      else $error("committed transaction not presented");

   // cursor never leaves the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (result.cursor_row < 4'(ROWS)) && (result.cursor_col < 4'(COLS)))
      else $error("cursor outside the screen");

endmodule

// ===== sv/tcss_row_mem.sv =====
// ----------------------------------------------------------------------------
// tcss_row_mem: row-wide screen memory
// One entry per screen row, with a registered synchronous read.
// A valid bit per row stands in for the clear: a row never written since
// the last clear reads as spaces.
// ----------------------------------------------------------------------------
module tcss_row_mem #(
   parameter int ROWS  = 10,
   parameter int COLS  = 10,
   parameter int ROW_W = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [ROW_W-1:0]           rd_addr,
   output logic [COLS*8-1:0]          rd_data,
   input  tcss_pkg::mem_ctl_type      ctl,
   input  logic [ROW_W-1:0]           wr_addr,
   input  logic [COLS*8-1:0]          wr_data
);

   logic [COLS*8-1:0] mem [ROWS];
   logic [COLS*8-1:0] rd_raw_ff;
   logic              rd_valid_ff;
   logic [ROWS-1:0]   row_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (ctl.clear_all) begin
            row_valid_ff <= '0;
         end else if (ctl.wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   // substitute a blank row for a row cleared since its last write
   assign rd_data = rd_valid_ff ? rd_raw_ff : {COLS{tcss_pkg::CHAR_SPACE}};

endmodule

// ===== sv/tcss_engine.sv =====
// ----------------------------------------------------------------------------
// tcss_engine: escape parser, cursor state and row edit
// Decode one transaction against the parser state, edit the fetched row
// and issue the write back; update state on commit.
// ----------------------------------------------------------------------------
module tcss_engine #(
   parameter int ROWS  = 10,
   parameter int COLS  = 10,
   parameter int ROW_W = 4,
   parameter int COL_W = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  commit,
   input  tcss_pkg::func_type    item_func,
   input  logic [7:0]            item_char,
   input  logic [COL_W-1:0]      item_col,
   input  logic                  item_hit,
   input  logic [COLS*8-1:0]     row_q,
   output logic [ROW_W-1:0]      row_pos,
   output tcss_pkg::mem_ctl_type mem_ctl,
   output logic [COLS*8-1:0]     wr_data,
   output tcss_pkg::rsp_type     result
);

   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);
   localparam logic [3:0]       ROW_MAX  = 4'(ROWS - 1);
   localparam logic [3:0]       COL_MAX  = 4'(COLS - 1);

   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic                ovr_ff, ovr_in;
   tcss_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          pend_ff, pend_in;

   logic                do_put, do_erase, do_clear;
   logic [7:0]          put_char;
   logic                is_digit;
   logic [7:0]          digit_wide;
   logic [3:0]          digit;
   logic [COLS*8-1:0]   shifted;

   assign digit_wide = item_char - tcss_pkg::CHAR_ZERO;
   assign digit      = digit_wide[3:0];
   assign is_digit   = (item_char >= tcss_pkg::CHAR_ZERO) &&
                       (item_char <= tcss_pkg::CHAR_NINE);

   // parser and cursor
   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      ovr_in   = ovr_ff;
      phase_in = phase_ff;
      pend_in  = pend_ff;
      do_put   = 1'b0;
      do_erase = 1'b0;
      do_clear = 1'b0;
      put_char = item_char;
      unique case (item_func)
         tcss_pkg::FUNC_FEED: begin
            unique case (phase_ff)
               tcss_pkg::PHASE_CARET: begin
                  phase_in = tcss_pkg::PHASE_NORMAL;
                  unique case (item_char)
                     tcss_pkg::CHAR_LOW_B: col_in = '0;
                     tcss_pkg::CHAR_LOW_C: do_clear = 1'b1;
                     tcss_pkg::CHAR_LOW_D: begin
                        if (row_ff != ROW_LAST) row_in = row_ff + 1'b1;
                     end
                     tcss_pkg::CHAR_LOW_E: do_erase = 1'b1;
                     tcss_pkg::CHAR_LOW_H: begin
                        row_in = '0;
                        col_in = '0;
                     end
                     tcss_pkg::CHAR_LOW_I: ovr_in = 1'b0;
                     tcss_pkg::CHAR_LOW_L: begin
                        if (col_ff != '0) col_in = col_ff - 1'b1;
                     end
                     tcss_pkg::CHAR_LOW_O: ovr_in = 1'b1;
                     tcss_pkg::CHAR_LOW_R: begin
                        if (col_ff != COL_LAST) col_in = col_ff + 1'b1;
                     end
                     tcss_pkg::CHAR_LOW_U: begin
                        if (row_ff != '0) row_in = row_ff - 1'b1;
                     end
                     tcss_pkg::CHAR_CARET: do_put = 1'b1;
                     default: begin
                        if (is_digit) begin
                           pend_in  = digit;
                           phase_in = tcss_pkg::PHASE_DIGIT;
                        end
                     end
                  endcase
               end
               tcss_pkg::PHASE_DIGIT: begin
                  phase_in = tcss_pkg::PHASE_NORMAL;
                  if (is_digit) begin
                     row_in = (pend_ff > ROW_MAX) ? ROW_LAST : pend_ff[ROW_W-1:0];
                     col_in = (digit > COL_MAX) ? COL_LAST : digit[COL_W-1:0];
                  end
               end
               default: begin
                  if (item_char == tcss_pkg::CHAR_CARET) begin
                     phase_in = tcss_pkg::PHASE_CARET;
                  end else if ((item_char >= tcss_pkg::CHAR_SPACE) &&
                               (item_char <= tcss_pkg::CHAR_TILDE)) begin
                     do_put = 1'b1;
                  end
               end
            endcase
         end
         tcss_pkg::FUNC_NEW: begin
            do_clear = 1'b1;
            row_in   = '0;
            col_in   = '0;
            ovr_in   = 1'b1;
            phase_in = tcss_pkg::PHASE_NORMAL;
            pend_in  = '0;
         end
         default: begin
         end
      endcase
      // advance after a write, stick at the last column
      if (do_put && (col_ff != COL_LAST)) begin
         col_in = col_ff + 1'b1;
      end
   end

   // row edit: insert shift, put and erase to end of line
   assign shifted = row_q << 8;

   always_comb begin
      for (int k = 0; k < COLS; k++) begin
         if (do_erase) begin
            wr_data[8*k +: 8] = (COL_W'(k) >= col_ff) ? tcss_pkg::CHAR_SPACE
                                                      : row_q[8*k +: 8];
         end else if (COL_W'(k) == col_ff) begin
            wr_data[8*k +: 8] = put_char;
         end else if ((COL_W'(k) > col_ff) && !ovr_ff) begin
            wr_data[8*k +: 8] = shifted[8*k +: 8];
         end else begin
            wr_data[8*k +: 8] = row_q[8*k +: 8];
         end
      end
   end

   assign mem_ctl.wr_en     = commit && (do_put || do_erase);
   assign mem_ctl.clear_all = commit && do_clear;
   assign row_pos           = row_ff;

   assign result.cell_char  = (item_hit && (item_func == tcss_pkg::FUNC_READ))
                              ? row_q[{item_col, 3'b000} +: 8] : 8'd0;
   assign result.cursor_row = 4'(row_in);
   assign result.cursor_col = 4'(col_in);
   assign result.insert_on  = ~ovr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         ovr_ff   <= 1'b1;
         phase_ff <= tcss_pkg::PHASE_NORMAL;
         pend_ff  <= '0;
      end else if (commit) begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         ovr_ff   <= ovr_in;
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// ===== dv/tcss_screen_checker.sv =====
// ----------------------------------------------------------------------------
// tcss_screen_checker: response predictor and comparator
// Watches the request and response streams of the terminal screen unit.
// It keeps its own copy of the screen, the cursor, the mode and the
// sequence parser, works out the response to every request transaction
// and compares each response transaction against it field by field.
// ----------------------------------------------------------------------------
module tcss_screen_checker #(
   parameter int ROWS = 10,
   parameter int COLS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   output int          fail_count,
   output int          pending
);

   logic [7:0]          cells [ROWS][COLS];
   int                  cur_row;
   int                  cur_col;
   logic                overwrite;
   tcss_pkg::phase_type phase;
   logic [3:0]          held_row;
   int                  errors;

   tcss_pkg::rsp_type   awaited_rsp [$];

   function automatic void wipe_screen();
      foreach (cells[r, c]) cells[r][c] = tcss_pkg::CHAR_SPACE;
   endfunction

   function automatic void restart_screen();
      wipe_screen();
      cur_row   = 0;
      cur_col   = 0;
      overwrite = 1'b1;
      phase     = tcss_pkg::PHASE_NORMAL;
      held_row  = '0;
   endfunction

   // write at the cursor; insert mode pushes the rest of the row right first
   function automatic void put_char(logic [7:0] ch);
      int k;
      if (!overwrite) begin
         for (k = COLS - 1; k > cur_col; k--) cells[cur_row][k] = cells[cur_row][k - 1];
      end
      cells[cur_row][cur_col] = ch;
      if (cur_col < COLS - 1) cur_col++;
   endfunction

   function automatic void apply_code(logic [7:0] ch);
      int k;
      phase = tcss_pkg::PHASE_NORMAL;
      case (ch)
         tcss_pkg::CHAR_LOW_B: cur_col = 0;
         tcss_pkg::CHAR_LOW_C: wipe_screen();
         tcss_pkg::CHAR_LOW_D: if (cur_row < ROWS - 1) cur_row++;
         tcss_pkg::CHAR_LOW_E: begin
            for (k = cur_col; k < COLS; k++) cells[cur_row][k] = tcss_pkg::CHAR_SPACE;
         end
         tcss_pkg::CHAR_LOW_H: begin
            cur_row = 0;
            cur_col = 0;
         end
         tcss_pkg::CHAR_LOW_I: overwrite = 1'b0;
         tcss_pkg::CHAR_LOW_L: if (cur_col > 0) cur_col--;
         tcss_pkg::CHAR_LOW_O: overwrite = 1'b1;
         tcss_pkg::CHAR_LOW_R: if (cur_col < COLS - 1) cur_col++;
         tcss_pkg::CHAR_LOW_U: if (cur_row > 0) cur_row--;
         tcss_pkg::CHAR_CARET: put_char(tcss_pkg::CHAR_CARET);
         default: begin
            if (ch >= tcss_pkg::CHAR_ZERO && ch <= tcss_pkg::CHAR_NINE) begin
               held_row = 4'(ch - tcss_pkg::CHAR_ZERO);
               phase    = tcss_pkg::PHASE_DIGIT;
            end
         end
      endcase
   endfunction

   function automatic tcss_pkg::rsp_type apply_request(tcss_pkg::func_type fn,
                                                       logic [7:0] ch,
                                                       logic [3:0] rr, logic [3:0] rc);
      tcss_pkg::rsp_type r;
      int                col_digit;
      r = '0;
      case (fn)
         tcss_pkg::FUNC_FEED: begin
            if (phase == tcss_pkg::PHASE_CARET) begin
               apply_code(ch);
            end else if (phase == tcss_pkg::PHASE_DIGIT) begin
               phase = tcss_pkg::PHASE_NORMAL;
               if (ch >= tcss_pkg::CHAR_ZERO && ch <= tcss_pkg::CHAR_NINE) begin
                  col_digit = ch - tcss_pkg::CHAR_ZERO;
                  cur_row   = (held_row > ROWS - 1) ? ROWS - 1 : held_row;
                  cur_col   = (col_digit > COLS - 1) ? COLS - 1 : col_digit;
               end
            end else if (ch == tcss_pkg::CHAR_CARET) begin
               phase = tcss_pkg::PHASE_CARET;
            end else if (ch >= tcss_pkg::CHAR_SPACE && ch <= tcss_pkg::CHAR_TILDE) begin
               put_char(ch);
            end
         end
         tcss_pkg::FUNC_READ: if (rr < ROWS && rc < COLS) r.cell_char = cells[rr][rc];
         tcss_pkg::FUNC_NEW:  restart_screen();
         default: ;
      endcase
      r.cursor_row = 4'(cur_row);
      r.cursor_col = 4'(cur_col);
      r.insert_on  = ~overwrite;
      return r;
   endfunction

   function automatic void flag(string field, int want_v, int got_v);
      errors++;
      if (errors <= 10)
         $display("mismatch %0d: %s expected %0d got %0d", errors, field, want_v, got_v);
   endfunction

   initial restart_screen();

   always @(posedge clock) begin
      tcss_pkg::rsp_type want;
      tcss_pkg::rsp_type got;
      if (reset) begin
         restart_screen();
         awaited_rsp.delete();
      end else begin
         // retire a response before queueing the request of the same edge
         if (rsp_tvalid && rsp_tready) begin
            got = tcss_pkg::rsp_type'(rsp_tdata[16:0]);
            if (awaited_rsp.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch %0d: response with none outstanding, data %h",
                           errors, rsp_tdata);
            end else begin
               want = awaited_rsp.pop_front();
               if (got.cell_char  !== want.cell_char)
                  flag("cell_char", want.cell_char, got.cell_char);
               if (got.cursor_row !== want.cursor_row)
                  flag("cursor_row", want.cursor_row, got.cursor_row);
               if (got.cursor_col !== want.cursor_col)
                  flag("cursor_col", want.cursor_col, got.cursor_col);
               if (got.insert_on  !== want.insert_on)
                  flag("insert_on", want.insert_on, got.insert_on);
            end
         end
         if (req_tvalid && req_tready)
            awaited_rsp.push_back(apply_request(tcss_pkg::func_type'(req_tuser),
                                                req_tdata[7:0],
                                                req_tdata[11:8], req_tdata[15:12]));
      end
      pending    <= awaited_rsp.size();
      fail_count <= errors;
   end

endmodule

// ===== dv/tb_terminal_control_sequence_screen_unit.sv =====
// ----------------------------------------------------------------------------
// tb_terminal_control_sequence_screen_unit: testbench top
// Drives byte feeds, cell reads and screen restarts into the terminal
// screen unit, first a short directed sequence and then random traffic
// that is mostly well-formed caret sequences and text, under three mixes
// of sender gaps and receiver stalls. A separate checker predicts and
// compares every response; this top only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_terminal_control_sequence_screen_unit;

   localparam int ROWS      = 10;
   localparam int COLS      = 10;
   localparam int LIMIT     = 300000;  // cycles; far beyond the slowest legal run
   localparam int PER_PHASE = 150;     // random request transactions per pressure mix

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;  // [7:0] char_code, [11:8] read_row, [15:12] read_col
   logic [1:0]  req_tuser  = '0;  // [1:0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [7:0] cell_char, [11:8] cursor_row,
                                  // [15:12] cursor_col, [16] insert_on

   int fail_count;
   int pending;
   int cycles        = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int n_sent        = 0;
   int n_feed        = 0;
   int n_read        = 0;
   int n_other       = 0;

   terminal_control_sequence_screen_unit #(.ROWS(ROWS), .COLS(COLS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tcss_screen_checker #(.ROWS(ROWS), .COLS(COLS)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   // Stall the response side at random; a single assignment per edge.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watchdog: end the run if the handshakes stop making progress.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Present one request transaction and hold it until accepted. Valid is
   // dropped only when a gap is taken, so back-to-back transactions keep it
   // high without a second assignment in the same step.
   task automatic send_req(input tcss_pkg::func_type fn, input logic [7:0] ch,
                           input logic [3:0] rr, input logic [3:0] rc);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rc, rr, ch};
      req_tuser  <= fn;
      do @(posedge clock); while (!req_tready);
      n_sent++;
      case (fn)
         tcss_pkg::FUNC_FEED: n_feed++;
         tcss_pkg::FUNC_READ: n_read++;
         default:             n_other++;
      endcase
   endtask

   // Feed one byte; the unused read fields carry random values.
   task automatic feed_byte(input logic [7:0] ch);
      send_req(tcss_pkg::FUNC_FEED, ch, 4'($urandom_range(15)), 4'($urandom_range(15)));
   endtask

   task automatic feed_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) feed_byte(s[i]);
   endtask

   task automatic read_cell(input logic [3:0] rr, input logic [3:0] rc);
      send_req(tcss_pkg::FUNC_READ, 8'($urandom_range(255)), rr, rc);
   endtask

   // Pick a control code; the screen clear is kept rare so the screen fills.
   function automatic logic [7:0] pick_code();
      case ($urandom_range(15))
         0:       return tcss_pkg::CHAR_LOW_B;
         1:       return tcss_pkg::CHAR_LOW_C;
         2, 3:    return tcss_pkg::CHAR_LOW_D;
         4:       return tcss_pkg::CHAR_LOW_E;
         5:       return tcss_pkg::CHAR_LOW_H;
         6:       return tcss_pkg::CHAR_LOW_I;
         7:       return tcss_pkg::CHAR_LOW_O;
         8, 9:    return tcss_pkg::CHAR_LOW_L;
         10, 11:  return tcss_pkg::CHAR_LOW_R;
         12, 13:  return tcss_pkg::CHAR_LOW_U;
         default: return tcss_pkg::CHAR_CARET;
      endcase
   endfunction

   task automatic random_step();
      int         pick;
      logic [7:0] ch;
      pick = $urandom_range(99);
      if (pick < 30) begin
         // printable text; a caret here would open a sequence instead
         ch = 8'($urandom_range(32, 126));
         if (ch == tcss_pkg::CHAR_CARET) ch = tcss_pkg::CHAR_TILDE;
         feed_byte(ch);
      end else if (pick < 58) begin
         feed_byte(tcss_pkg::CHAR_CARET);
         feed_byte(pick_code());
      end else if (pick < 68) begin
         // absolute cursor position
         feed_byte(tcss_pkg::CHAR_CARET);
         feed_byte(8'($urandom_range(tcss_pkg::CHAR_ZERO, tcss_pkg::CHAR_NINE)));
         feed_byte(8'($urandom_range(tcss_pkg::CHAR_ZERO, tcss_pkg::CHAR_NINE)));
      end else if (pick < 84) begin
         // mostly on-screen reads, now and then off the edge
         if ($urandom_range(7) == 0)
            read_cell(4'($urandom_range(15)), 4'($urandom_range(15)));
         else
            read_cell(4'($urandom_range(ROWS - 1)), 4'($urandom_range(COLS - 1)));
      end else if (pick < 94) begin
         // noise: stray bytes and broken sequences
         case ($urandom_range(2))
            0: feed_byte(8'($urandom_range(255)));
            1: begin
               feed_byte(tcss_pkg::CHAR_CARET);
               feed_byte(8'($urandom_range(255)));
            end
            default: begin
               feed_byte(tcss_pkg::CHAR_CARET);
               feed_byte(8'($urandom_range(tcss_pkg::CHAR_ZERO, tcss_pkg::CHAR_NINE)));
               feed_byte(8'($urandom_range(255)));
            end
         endcase
      end else if (pick < 97) begin
         send_req(tcss_pkg::FUNC_NEW, 8'($urandom_range(255)),
                  4'($urandom_range(15)), 4'($urandom_range(15)));
      end else begin
         send_req(tcss_pkg::FUNC_NONE, 8'($urandom_range(255)),
                  4'($urandom_range(15)), 4'($urandom_range(15)));
      end
   endtask

   task automatic run_mix(input int idle_pct, input int stall_pct, input int goal);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      while (n_sent < goal) random_step();
   endtask

   initial begin
      int base;

      // Hold reset, then release it once.
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      rsp_stall_pct = 54;

      // Directed: fresh screen read, text extremes, ignored bytes
      read_cell(4'd0, 4'd0);
      feed_byte(tcss_pkg::CHAR_TILDE);
      feed_byte(8'hFF);
      // doubled caret writes a caret
      feed_text("^^");
      // jump to the far corner and stick at the last column
      feed_text("^99Z");
      // insert mode at home shifts the row right
      feed_text("^i^hQ");
      feed_text("^e");
      // unknown code, then a digit followed by a non-digit
      feed_text("^q");
      feed_text("^5x");
      // read off the screen, the unused function, and a new screen
      read_cell(4'd15, 4'd15);
      send_req(tcss_pkg::FUNC_NONE, 8'h00, 4'd0, 4'd0);
      send_req(tcss_pkg::FUNC_NEW, 8'hFF, 4'd15, 4'd15);

      // Random traffic under three pressure mixes.
      base = n_sent;
      run_mix(20, 54, base + PER_PHASE);
      run_mix(54, 20, base + 2 * PER_PHASE);
      run_mix(0, 0, base + 3 * PER_PHASE);

      // Drop valid and drain, waiting on the clock so the count is current.
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);

      $display("covered %0d request transactions: %0d byte feeds, %0d cell reads,",
               n_sent, n_feed, n_read);
      $display("%0d restarts or unused codes, over three gap and stall mixes",
               n_other);
      if (fail_count == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== terminal_control_sequence_screen_unit.f =====
sv/tcss_pkg.sv
sv/tcss_row_mem.sv
sv/tcss_engine.sv
sv/terminal_control_sequence_screen_unit.sv
dv/tcss_screen_checker.sv
dv/tb_terminal_control_sequence_screen_unit.sv
